### src/mmlm_pkg.sv
`default_nettype none
package mmlm_pkg;

   localparam int unsigned MaxPorts = 4;

   typedef logic signed [15:0] sample_type;

   // configuration register indexes
   localparam logic [1:0] RegPresent  = 2'd0;
   localparam logic [1:0] RegForward  = 2'd1;
   localparam logic [1:0] RegTransmit = 2'd2;

   typedef struct packed {
      logic [MaxPorts-1:0] present;
      logic [MaxPorts-1:0] forward;
      logic [MaxPorts-1:0] transmit;
   } cfg_type;

   typedef struct packed {
      logic [MaxPorts-1:0]       port_active_mask;
      logic [MaxPorts-1:0][15:0] port_sample;
      logic                      receiving;
      sample_type                local_sample;
   } in_type;

   typedef struct packed {
      sample_type                local_gated;
      logic [MaxPorts-1:0][15:0] present_sample;
      logic [MaxPorts-1:0][15:0] forward_sample;
      logic [MaxPorts-1:0]       present;
      logic [MaxPorts-1:0]       send_key;
      logic                      any_link;
   } gate_type;

   typedef struct packed {
      logic signed [17:0]        remote_sum;
      logic signed [18:0]        forward_sum;
      logic [MaxPorts-1:0][15:0] forward_sample;
      logic [MaxPorts-1:0]       present;
      logic [MaxPorts-1:0]       send_key;
      logic                      any_link;
   } sum_type;

   typedef struct packed {
      sample_type                remote_mix;
      logic [MaxPorts-1:0][15:0] port_mix;
      logic [MaxPorts-1:0]       send_key_mask;
      logic                      any_link;
   } out_type;

   function automatic logic [15:0] sat16(input logic signed [18:0] v);
      logic [15:0] r;
      if (v > 19'sd32767) begin
         r = 16'h7fff;
      end else if (v < -19'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/mmlm_gate.sv
`default_nettype none
module mmlm_gate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire mmlm_pkg::in_type  in_data,
   input  wire mmlm_pkg::cfg_type cfg,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output mmlm_pkg::gate_type     out_data
);

   logic                         valid_ff;
   mmlm_pkg::gate_type           data_ff;
   mmlm_pkg::gate_type           data_in;
   logic [mmlm_pkg::MaxPorts-1:0] fwd;
   logic [mmlm_pkg::MaxPorts-1:0] act;
   logic [mmlm_pkg::MaxPorts-1:0] fwd_act;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      fwd     = cfg.forward & cfg.present;
      act     = in_data.port_active_mask & cfg.present;
      fwd_act = act & fwd;
      data_in.local_gated = in_data.receiving ? in_data.local_sample : '0;
      data_in.present     = cfg.present;
      data_in.any_link    = |act;
      for (int p = 0; p < mmlm_pkg::MaxPorts; p++) begin
         data_in.present_sample[p] = cfg.present[p] ? in_data.port_sample[p] : '0;
         data_in.forward_sample[p] = fwd[p] ? in_data.port_sample[p] : '0;
         // key on local receive or on activity from another forwarding port
         data_in.send_key[p] = cfg.present[p] & cfg.transmit[p] &
            (in_data.receiving |
             (|(fwd_act & ~(mmlm_pkg::MaxPorts'(1) << p))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### src/mmlm_sum.sv
`default_nettype none
module mmlm_sum (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire mmlm_pkg::gate_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output mmlm_pkg::sum_type       out_data
);

   logic              valid_ff;
   mmlm_pkg::sum_type data_ff;
   mmlm_pkg::sum_type data_in;
   logic signed [17:0] remote_acc;
   logic signed [18:0] forward_acc;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      remote_acc  = '0;
      forward_acc = {{3{in_data.local_gated[15]}}, in_data.local_gated};
      for (int p = 0; p < mmlm_pkg::MaxPorts; p++) begin
         remote_acc  = remote_acc +
            {{2{in_data.present_sample[p][15]}}, in_data.present_sample[p]};
         forward_acc = forward_acc +
            {{3{in_data.forward_sample[p][15]}}, in_data.forward_sample[p]};
      end
      data_in.remote_sum     = remote_acc;
      data_in.forward_sum    = forward_acc;
      data_in.forward_sample = in_data.forward_sample;
      data_in.present        = in_data.present;
      data_in.send_key       = in_data.send_key;
      data_in.any_link       = in_data.any_link;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### src/mmlm_sat.sv
`default_nettype none
module mmlm_sat (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire mmlm_pkg::sum_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output mmlm_pkg::out_type      out_data
);

   logic              valid_ff;
   mmlm_pkg::out_type data_ff;
   mmlm_pkg::out_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.remote_mix    = mmlm_pkg::sat16({in_data.remote_sum[17], in_data.remote_sum});
      data_in.send_key_mask = in_data.send_key;
      data_in.any_link      = in_data.any_link;
      for (int p = 0; p < mmlm_pkg::MaxPorts; p++) begin
         // remove the port's own forwarded sample from the full forward mix
         data_in.port_mix[p] = in_data.present[p] ?
            mmlm_pkg::sat16(in_data.forward_sum -
               {{3{in_data.forward_sample[p][15]}}, in_data.forward_sample[p]}) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### src/mix_minus_link_mixer_core.sv
// A transaction accepted on req_ is registered in turn by three register stages
// (gate and key, sum, saturate and output register) and then shows on rsp_.
// The pipeline takes one transaction per cycle while rsp_ is not stalled; a stall
// on rsp_ holds every full stage, while empty stages still fill.
// Reset (synchronous, active high) clears the configuration registers to zero
// and empties the pipeline; no clearing pass is needed.
`default_nettype none
module mix_minus_link_mixer_core #(
   parameter int unsigned PORT_COUNT = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // local_sample, port0_sample, port1_sample, port2_sample, port3_sample,
   // port_active_mask, zero fill
   input  wire logic [87:0] req_tdata,
   // receiving
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // remote_mix, out0_mix, out1_mix, out2_mix, out3_mix, send_key_mask, zero fill
   output logic [87:0]      rsp_tdata,
   // any_link
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);

   localparam logic [mmlm_pkg::MaxPorts-1:0] PortLimit =
      mmlm_pkg::MaxPorts'((1 << PORT_COUNT) - 1);

   logic [3:0]         present_ff;
   logic [3:0]         forward_ff;
   logic [3:0]         transmit_ff;
   mmlm_pkg::cfg_type  cfg;
   mmlm_pkg::in_type   req_data;
   mmlm_pkg::gate_type gate_data;
   mmlm_pkg::sum_type  sum_data;
   mmlm_pkg::out_type  rsp_data;
   logic               gate_valid;
   logic               gate_ready;
   logic               sum_valid;
   logic               sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         forward_ff  <= '0;
         transmit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mmlm_pkg::RegPresent:  present_ff  <= csr_wdata;
            mmlm_pkg::RegForward:  forward_ff  <= csr_wdata;
            mmlm_pkg::RegTransmit: transmit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ports beyond the configured count never take part
   assign cfg.present  = present_ff & PortLimit;
   assign cfg.forward  = forward_ff;
   assign cfg.transmit = transmit_ff;

   assign req_data.local_sample     = req_tdata[15:0];
   assign req_data.receiving        = req_tuser[0];
   assign req_data.port_sample[0]   = req_tdata[31:16];
   assign req_data.port_sample[1]   = req_tdata[47:32];
   assign req_data.port_sample[2]   = req_tdata[63:48];
   assign req_data.port_sample[3]   = req_tdata[79:64];
   assign req_data.port_active_mask = req_tdata[83:80];

   mmlm_gate u_gate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (gate_valid),
      .out_ready (gate_ready),
      .out_data  (gate_data)
   );

   mmlm_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gate_valid),
      .in_ready  (gate_ready),
      .in_data   (gate_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   mmlm_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {4'b0000, rsp_data.send_key_mask,
                       rsp_data.port_mix[3], rsp_data.port_mix[2],
                       rsp_data.port_mix[1], rsp_data.port_mix[0],
                       rsp_data.remote_mix};
   assign rsp_tuser = rsp_data.any_link;

`ifndef ASSERT_OFF
   a_key_present: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[83:80] & ~cfg.present) == 4'b0000))
      else $error("send key raised toward an absent port");

   a_link_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (cfg.present != 4'b0000))
      else $error("link active with no port present");

   a_absent_mix: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !cfg.present[0]) |-> (rsp_tdata[31:16] == 16'h0000))
      else $error("mix toward absent port 0 not zero");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      (!req_tready) |-> (gate_valid && sum_valid && rsp_tvalid && !rsp_tready))
      else $error("input stalled while pipeline has room");
`endif

endmodule
`default_nettype wire
